>>> rtl/core/ows_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 1-wire slave command layer.
// No dependencies; imported by every module of the block.
package ows_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROM_CODE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCRATCH_DATA = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SENSOR_CODE  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SENSOR_FAULT = 2'd3;

    // ROM layer commands
    localparam logic [7:0] CMD_READ_ROM   = 8'h33;
    localparam logic [7:0] CMD_SEARCH_ROM = 8'hF0;
    localparam logic [7:0] CMD_MATCH_ROM  = 8'h55;
    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    // function layer commands
    localparam logic [7:0] CMD_CONVERT    = 8'h44;
    localparam logic [7:0] CMD_READ_SCR   = 8'hBE;

    // search sub-steps within one ROM bit
    localparam logic [1:0] SUB_SEND_BIT  = 2'd0;
    localparam logic [1:0] SUB_SEND_COMP = 2'd1;
    localparam logic [1:0] SUB_READ_DIR  = 2'd2;

    localparam int ROM_BITS     = 64;
    localparam int SCRATCH_BITS = 48;
    localparam int SENSOR_BITS  = 8;
    localparam int CMD_BITS     = 8;

    typedef struct packed {
        logic [63:0] rom_code;
        logic [47:0] scratch_data;
        logic [7:0]  sensor_code;
        logic        sensor_fault;
    } ows_cfg_t;

    typedef struct packed {
        logic slave_bit;
        logic presence;
        logic start_conversion;
    } ows_result_t;

endpackage

>>> rtl/core/ows_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file of the 1-wire slave command layer.
// Depends on ows_pkg for register indexes and the config struct.
module ows_cfg_regs
    import ows_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output ows_cfg_t               cfg
);

    ows_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROM_CODE:     cfg_reg.rom_code     <= cfg_data;
                CFG_SCRATCH_DATA: cfg_reg.scratch_data <= cfg_data[47:0];
                CFG_SENSOR_CODE:  cfg_reg.sensor_code  <= cfg_data[7:0];
                CFG_SENSOR_FAULT: cfg_reg.sensor_fault <= cfg_data[0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/ows_cmd_fsm.sv
`timescale 1ns / 1ps
// ROM and function command sequencer: bus state plus the result of one event.
// Depends on ows_pkg for command codes, config and result structs.
module ows_cmd_fsm
    import ows_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        cmd,
    input  logic        master_bit,
    input  ows_cfg_t    cfg,
    output ows_result_t res
);

    typedef enum logic [2:0] {
        PH_WAIT   = 3'd0,
        PH_ROMCMD = 3'd1,
        PH_READ   = 3'd2,
        PH_SEARCH = 3'd3,
        PH_MATCH  = 3'd4,
        PH_FUNC   = 3'd5,
        PH_SCRAT  = 3'd6
    } phase_t;

    phase_t      phase_reg,  phase_next;
    logic [7:0]  shift_reg,  shift_next;
    logic [6:0]  index_reg,  index_next;
    logic [1:0]  sub_reg,    sub_next;

    logic [6:0]  index_inc;
    logic [7:0]  shift_in;
    logic        rom_bit;
    logic        scr_bit;

    assign index_inc = index_reg + 7'd1;
    assign shift_in  = {master_bit, shift_reg[7:1]};
    assign rom_bit   = cfg.rom_code[index_reg[5:0]];
    // sensor byte index is index - 48, and 48 is a multiple of 8
    assign scr_bit   = (index_reg < 7'(SCRATCH_BITS)) ? cfg.scratch_data[index_reg[5:0]]
                                                       : cfg.sensor_code[index_reg[2:0]];

    always_comb
    begin
        phase_next           = phase_reg;
        shift_next           = shift_reg;
        index_next           = index_reg;
        sub_next             = sub_reg;
        res.slave_bit        = 1'b1;
        res.presence         = 1'b0;
        res.start_conversion = 1'b0;

        if (!cmd)
        begin
            res.presence = 1'b1;
            phase_next   = PH_ROMCMD;
            shift_next   = '0;
            index_next   = '0;
            sub_next     = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_ROMCMD:
                begin
                    shift_next = shift_in;
                    index_next = index_inc;
                    if (index_inc >= 7'(CMD_BITS))
                    begin
                        shift_next = '0;
                        index_next = '0;
                        sub_next   = '0;
                        case (shift_in)
                            CMD_READ_ROM:   phase_next = PH_READ;
                            CMD_SEARCH_ROM: phase_next = PH_SEARCH;
                            CMD_MATCH_ROM:  phase_next = PH_MATCH;
                            CMD_SKIP_ROM:   phase_next = PH_FUNC;
                            default:        phase_next = PH_WAIT;
                        endcase
                    end
                end
                PH_READ:
                begin
                    res.slave_bit = rom_bit;
                    index_next    = index_inc;
                    if (index_inc >= 7'(ROM_BITS))
                    begin
                        phase_next = PH_WAIT;
                        index_next = '0;
                    end
                end
                PH_SEARCH:
                begin
                    case (sub_reg)
                        SUB_SEND_BIT:
                        begin
                            res.slave_bit = rom_bit;
                            sub_next      = SUB_SEND_COMP;
                        end
                        SUB_SEND_COMP:
                        begin
                            res.slave_bit = ~rom_bit;
                            sub_next      = SUB_READ_DIR;
                        end
                        SUB_READ_DIR:
                        begin
                            sub_next = SUB_SEND_BIT;
                            if (master_bit != rom_bit || index_inc >= 7'(ROM_BITS))
                            begin
                                phase_next = PH_WAIT;
                                index_next = '0;
                            end
                            else
                            begin
                                index_next = index_inc;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_WAIT;
                            index_next = '0;
                            sub_next   = '0;
                        end
                    endcase
                end
                PH_MATCH:
                begin
                    index_next = index_inc;
                    if (master_bit != rom_bit)
                    begin
                        phase_next = PH_WAIT;
                        index_next = '0;
                    end
                    else if (index_inc >= 7'(ROM_BITS))
                    begin
                        phase_next = PH_FUNC;
                        index_next = '0;
                    end
                end
                PH_FUNC:
                begin
                    shift_next = shift_in;
                    index_next = index_inc;
                    if (index_inc >= 7'(CMD_BITS))
                    begin
                        shift_next = '0;
                        index_next = '0;
                        sub_next   = '0;
                        if (shift_in == CMD_CONVERT)
                        begin
                            res.start_conversion = 1'b1;
                            phase_next           = PH_WAIT;
                        end
                        else if (shift_in == CMD_READ_SCR && !cfg.sensor_fault)
                        begin
                            phase_next = PH_SCRAT;
                        end
                        else
                        begin
                            phase_next = PH_WAIT;
                        end
                    end
                end
                PH_SCRAT:
                begin
                    res.slave_bit = scr_bit;
                    index_next    = index_inc;
                    if (index_inc >= 7'(SCRATCH_BITS + SENSOR_BITS))
                    begin
                        phase_next = PH_WAIT;
                        index_next = '0;
                    end
                end
                default:
                begin
                    // waiting for reset, or an unused code: park and release the line
                    phase_next = PH_WAIT;
                    shift_next = '0;
                    index_next = '0;
                    sub_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            shift_reg <= '0;
            index_reg <= '0;
            sub_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            index_reg <= index_next;
            sub_reg   <= sub_next;
        end
    end

    a_reset_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !cmd |=> phase_reg == PH_ROMCMD && index_reg == 7'd0)
        else $error("reset event did not restart ROM command reception");

    a_conv_from_func: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.start_conversion |-> phase_reg == PH_FUNC && cmd)
        else $error("start_conversion outside the function phase");

    a_drive_only_sending: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !res.slave_bit |->
            (phase_reg == PH_READ || phase_reg == PH_SEARCH || phase_reg == PH_SCRAT))
        else $error("line pulled low while not sending");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        index_reg < 7'(ROM_BITS))
        else $error("bit counter overran the ROM length");

    a_sub_legal: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg != 2'd3)
        else $error("search sub-step left its range");

endmodule

>>> rtl/core/onewire_slave_command_layer.sv
`timescale 1ns / 1ps
// 1-wire slave ROM/function command layer: input stage, sequencer, result stage.
// Depends on ows_pkg, ows_cfg_regs and ows_cmd_fsm.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one bus event per beat:
//   cmd = 0 for a reset pulse, cmd = 1 for one time slot with master_bit.
//   Output channel (out_valid / out_stall) returns exactly one result beat per
//   event: slave_bit (0 pulls the line low), presence, start_conversion.
//   A beat moves at a rising edge with valid high and stall low.
//   Path: an accepted event waits in the input register, passes the
//   combinational sequencer and is presented from the result register.
//   Throughput: one event per cycle while out_stall is low, set by the
//   combinational sequencer between the two registers.
//   When out_stall is held, the result register holds and one more event
//   waits in the input register; in_stall then rises until the result moves.
//   Configuration: cfg_we writes cfg_data to register cfg_index (0 rom_code,
//   1 scratch_data, 2 sensor_code, 3 sensor_fault); write only while idle.
//   Reset clears both valid flags, the configuration registers and the
//   sequencer state, and leaves the bus sequencer waiting for a reset pulse.
module onewire_slave_command_layer
    import ows_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   cmd,
    input  logic                   master_bit,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   slave_bit,
    output logic                   presence,
    output logic                   start_conversion
);

    ows_cfg_t    cfg;
    ows_result_t res;

    logic        in_vld_reg;
    logic        cmd_reg;
    logic        mb_reg;
    logic        out_vld_reg;
    ows_result_t out_reg;
    logic        advance;
    logic        in_take;

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    ows_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ows_cmd_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .cmd        (cmd_reg),
        .master_bit (mb_reg),
        .cfg        (cfg),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg <= cmd;
            mb_reg  <= master_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign out_valid        = out_vld_reg;
    assign slave_bit        = out_reg.slave_bit;
    assign presence         = out_reg.presence;
    assign start_conversion = out_reg.start_conversion;

endmodule

>>> dv/ows_bus_checker.sv
`timescale 1ns / 1ps
// Result checker for the 1-wire slave command layer: tracks register writes,
// predicts one result beat per accepted bus event and compares in order.
// Depends on ows_pkg.
module ows_bus_checker
    import ows_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic                   cmd,
    input  logic                   master_bit,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic                   slave_bit,
    input  logic                   presence,
    input  logic                   start_conversion,
    output int                     fail_count,
    output int                     pending
);

    typedef enum logic [2:0] {
        ST_WAIT_RESET,
        ST_ROM_CMD,
        ST_SEND_ROM,
        ST_SEARCH,
        ST_MATCH,
        ST_FUNC_CMD,
        ST_SEND_SCRATCH
    } bus_state_t;

    ows_cfg_t    regs;
    bus_state_t  bus_st;
    logic [7:0]  shift_byte;
    logic [6:0]  bit_cnt;
    logic [1:0]  search_step;
    ows_result_t expected_slots[$];
    ows_result_t event_result;
    ows_result_t oldest;

    task automatic enter_state(input bus_state_t s);
        bus_st      = s;
        shift_byte  = '0;
        bit_cnt     = '0;
        search_step = SUB_SEND_BIT;
    endtask

    // shift in LSB first; done once the eighth bit is in
    task automatic take_command_bit(input logic b, output logic done);
        shift_byte = {b, shift_byte[7:1]};
        bit_cnt    = bit_cnt + 7'd1;
        done       = (bit_cnt >= CMD_BITS);
    endtask

    task automatic advance_bus(input logic c, input logic b, output ows_result_t r);
        logic       done;
        logic [6:0] sens_idx;
        r.slave_bit        = 1'b1;
        r.presence         = 1'b0;
        r.start_conversion = 1'b0;
        if (!c)
        begin
            r.presence = 1'b1;
            enter_state(ST_ROM_CMD);
        end
        else
        begin
            case (bus_st)
                ST_ROM_CMD:
                begin
                    take_command_bit(b, done);
                    if (done)
                    begin
                        case (shift_byte)
                            CMD_READ_ROM:   enter_state(ST_SEND_ROM);
                            CMD_SEARCH_ROM: enter_state(ST_SEARCH);
                            CMD_MATCH_ROM:  enter_state(ST_MATCH);
                            CMD_SKIP_ROM:   enter_state(ST_FUNC_CMD);
                            default:        enter_state(ST_WAIT_RESET);
                        endcase
                    end
                end
                ST_SEND_ROM:
                begin
                    r.slave_bit = regs.rom_code[bit_cnt[5:0]];
                    bit_cnt = bit_cnt + 7'd1;
                    if (bit_cnt >= ROM_BITS)
                        enter_state(ST_WAIT_RESET);
                end
                ST_SEARCH:
                begin
                    case (search_step)
                        SUB_SEND_BIT:
                        begin
                            r.slave_bit = regs.rom_code[bit_cnt[5:0]];
                            search_step = SUB_SEND_COMP;
                        end
                        SUB_SEND_COMP:
                        begin
                            r.slave_bit = ~regs.rom_code[bit_cnt[5:0]];
                            search_step = SUB_READ_DIR;
                        end
                        SUB_READ_DIR:
                        begin
                            // master picked the other branch: drop out
                            if (b != regs.rom_code[bit_cnt[5:0]])
                                enter_state(ST_WAIT_RESET);
                            else
                            begin
                                search_step = SUB_SEND_BIT;
                                bit_cnt = bit_cnt + 7'd1;
                                if (bit_cnt >= ROM_BITS)
                                    enter_state(ST_WAIT_RESET);
                            end
                        end
                        default: enter_state(ST_WAIT_RESET);
                    endcase
                end
                ST_MATCH:
                begin
                    if (b != regs.rom_code[bit_cnt[5:0]])
                        enter_state(ST_WAIT_RESET);
                    else
                    begin
                        bit_cnt = bit_cnt + 7'd1;
                        if (bit_cnt >= ROM_BITS)
                            enter_state(ST_FUNC_CMD);
                    end
                end
                ST_FUNC_CMD:
                begin
                    take_command_bit(b, done);
                    if (done)
                    begin
                        if (shift_byte == CMD_CONVERT)
                        begin
                            r.start_conversion = 1'b1;
                            enter_state(ST_WAIT_RESET);
                        end
                        else if (shift_byte == CMD_READ_SCR && !regs.sensor_fault)
                            enter_state(ST_SEND_SCRATCH);
                        else
                            enter_state(ST_WAIT_RESET);
                    end
                end
                ST_SEND_SCRATCH:
                begin
                    sens_idx = bit_cnt - 7'd48;
                    if (bit_cnt < SCRATCH_BITS)
                        r.slave_bit = regs.scratch_data[bit_cnt[5:0]];
                    else
                        r.slave_bit = regs.sensor_code[sens_idx[2:0]];
                    bit_cnt = bit_cnt + 7'd1;
                    if (bit_cnt >= SCRATCH_BITS + SENSOR_BITS)
                        enter_state(ST_WAIT_RESET);
                end
                // slots while waiting for reset are ignored
                default: enter_state(ST_WAIT_RESET);
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs = '0;
            enter_state(ST_WAIT_RESET);
            expected_slots.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ROM_CODE:     regs.rom_code     = cfg_data;
                    CFG_SCRATCH_DATA: regs.scratch_data = cfg_data[47:0];
                    CFG_SENSOR_CODE:  regs.sensor_code  = cfg_data[7:0];
                    CFG_SENSOR_FAULT: regs.sensor_fault = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                advance_bus(cmd, master_bit, event_result);
                expected_slots.push_back(event_result);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_slots.size() == 0)
                begin
                    $error("result beat with no bus event waiting");
                    fail_count++;
                end
                else
                begin
                    oldest = expected_slots.pop_front();
                    if (slave_bit !== oldest.slave_bit)
                    begin
                        $error("slave_bit: expected %0b, got %0b", oldest.slave_bit, slave_bit);
                        fail_count++;
                    end
                    if (presence !== oldest.presence)
                    begin
                        $error("presence: expected %0b, got %0b", oldest.presence, presence);
                        fail_count++;
                    end
                    if (start_conversion !== oldest.start_conversion)
                    begin
                        $error("start_conversion: expected %0b, got %0b",
                               oldest.start_conversion, start_conversion);
                        fail_count++;
                    end
                end
            end
            pending = expected_slots.size();
        end
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Top of the 1-wire slave command layer bench: clock, reset, bus event
// stimulus, receiver stalls and verdict. Depends on ows_pkg, ows_bus_checker
// and the onewire_slave_command_layer RTL.
module testbench;
    import ows_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic                   cmd;
    logic                   master_bit;
    logic                   out_valid;
    logic                   out_stall;
    logic                   slave_bit;
    logic                   presence;
    logic                   start_conversion;
    int                     fail_count;
    int                     pending;

    logic        squeeze_req;
    int          sent;
    int          burst_left;
    logic [63:0] rom_now;

    always #6 clk = ~clk;

    onewire_slave_command_layer u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .master_bit       (master_bit),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .slave_bit        (slave_bit),
        .presence         (presence),
        .start_conversion (start_conversion)
    );

    ows_bus_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .master_bit       (master_bit),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .slave_bit        (slave_bit),
        .presence         (presence),
        .start_conversion (start_conversion),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    // mostly back-to-back, some short gaps, a few long ones, and gapless bursts
    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if (r < 4)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // called at a falling edge; returns at the falling edge after the beat moves
    task automatic put_event(input logic c, input logic b);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        cmd        = c;
        master_bit = b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic bus_reset();
        put_event(1'b0, 1'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] val);
        for (int i = 0; i < 8; i++)
            put_event(1'b1, val[i]);
    endtask

    // master reads: line released, now and then a stray zero
    task automatic read_slots(input int n);
        for (int i = 0; i < n; i++)
            put_event(1'b1, ($urandom_range(0, 9) == 0) ? 1'($urandom) : 1'b1);
    endtask

    task automatic noise(input int n, input bit with_resets);
        for (int i = 0; i < n; i++)
            put_event(with_resets ? 1'($urandom_range(0, 3) != 0) : 1'b1, 1'($urandom));
    endtask

    task automatic function_phase();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            send_byte(CMD_CONVERT);
        else if (r < 80)
        begin
            send_byte(CMD_READ_SCR);
            read_slots(($urandom_range(0, 9) < 7) ? 56 : $urandom_range(0, 60));
        end
        else
            send_byte(8'($urandom));
        noise($urandom_range(0, 3), 1'b0);
    endtask

    task automatic run_sequence();
        int r;
        int fail_at;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            bus_reset();
            send_byte(CMD_READ_ROM);
            read_slots(($urandom_range(0, 9) < 7) ? 64 : $urandom_range(0, 70));
            noise($urandom_range(0, 2), 1'b0);
        end
        else if (r < 27)
        begin
            bus_reset();
            send_byte(CMD_SEARCH_ROM);
            fail_at = ($urandom_range(0, 99) < 40) ? ROM_BITS : $urandom_range(0, 63);
            for (int k = 0; k < ROM_BITS; k++)
            begin
                read_slots(2);
                if (k == fail_at)
                begin
                    put_event(1'b1, ~rom_now[k]);
                    break;
                end
                put_event(1'b1, rom_now[k]);
            end
            noise($urandom_range(0, 2), 1'b0);
        end
        else if (r < 45)
        begin
            bus_reset();
            send_byte(CMD_MATCH_ROM);
            fail_at = ($urandom_range(0, 99) < 60) ? ROM_BITS : $urandom_range(0, 63);
            for (int k = 0; k < ROM_BITS; k++)
                put_event(1'b1, (k == fail_at) ? ~rom_now[k] : rom_now[k]);
            if (fail_at == ROM_BITS)
                function_phase();
            else
                noise($urandom_range(0, 3), 1'b0);
        end
        else if (r < 75)
        begin
            bus_reset();
            send_byte(CMD_SKIP_ROM);
            function_phase();
        end
        else if (r < 85)
        begin
            bus_reset();
            send_byte(8'($urandom));
            noise($urandom_range(0, 4), 1'b0);
        end
        else if (r < 93)
        begin
            // abandon a transfer part way with a fresh reset
            bus_reset();
            send_byte(($urandom_range(0, 1) != 0) ? CMD_READ_ROM : CMD_SKIP_ROM);
            noise($urandom_range(0, 20), 1'b0);
            bus_reset();
        end
        else
            noise($urandom_range(1, 12), 1'b1);
    endtask

    task automatic quiesce();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_regs(input logic [63:0] rom, input logic [47:0] scr,
                             input logic [7:0] sens, input logic fault);
        rom_now   = rom;
        cfg_we    = 1'b1;
        cfg_index = CFG_ROM_CODE;
        cfg_data  = rom;
        @(negedge clk);
        cfg_index = CFG_SCRATCH_DATA;
        cfg_data  = {16'd0, scr};
        @(negedge clk);
        cfg_index = CFG_SENSOR_CODE;
        cfg_data  = {56'd0, sens};
        @(negedge clk);
        cfg_index = CFG_SENSOR_FAULT;
        cfg_data  = {63'd0, fault};
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // receiver: quiet stretches, short and long stalls, one long hold-off
    initial
    begin
        int  r;
        int  quiet_left;
        int  stall_left;
        bit  squeezed;
        quiet_left = 0;
        stall_left = 0;
        squeezed   = 1'b0;
        out_stall  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (squeeze_req && !squeezed)
            begin
                squeezed  = 1'b1;
                out_stall = 1'b1;
                repeat (80) @(negedge clk);
                out_stall = 1'b0;
            end
            else if (quiet_left > 0)
            begin
                out_stall = 1'b0;
                quiet_left--;
            end
            else if (stall_left > 0)
            begin
                out_stall = 1'b1;
                stall_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    quiet_left = $urandom_range(20, 80);
                else if (r < 6)
                    stall_left = $urandom_range(8, 30);
                else if (r < 35)
                    stall_left = $urandom_range(1, 3);
                out_stall = 1'b0;
            end
        end
    end

    initial
    begin
        int target;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_ROM_CODE;
        cfg_data    = '0;
        in_valid    = 1'b0;
        cmd         = 1'b1;
        master_bit  = 1'b1;
        squeeze_req = 1'b0;
        sent        = 0;
        burst_left  = 0;
        rom_now     = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        load_regs({$urandom, $urandom}, {16'($urandom), 32'($urandom)}, 8'($urandom), 1'b0);

        // slots before any reset are ignored, then skip ROM into convert,
        // then back-to-back resets
        put_event(1'b1, 1'b0);
        put_event(1'b1, 1'b1);
        put_event(1'b0, 1'b1);
        send_byte(CMD_SKIP_ROM);
        send_byte(CMD_CONVERT);
        put_event(1'b0, 1'b0);
        put_event(1'b0, 1'b1);

        for (int ph = 0; ph < 4; ph++)
        begin
            quiesce();
            case (ph)
                0: load_regs('1, '1, 8'hFF, 1'b1);
                1: load_regs('0, '0, 8'h00, 1'b0);
                2: load_regs({$urandom, $urandom}, {16'($urandom), 32'($urandom)},
                             8'($urandom), 1'b1);
                default: load_regs({$urandom, $urandom}, {16'($urandom), 32'($urandom)},
                                   8'($urandom), 1'b0);
            endcase
            if (ph == 0)
                squeeze_req = 1'b1;
            target = sent + 215;
            while (sent < target)
                run_sequence();
        end

        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
